// ===== sv/rmths_pkg.sv =====
// rmths_pkg: word types and fixed widths for the running median block
// no dependencies; imported by running_median_two_heap_signed_sum
`default_nettype none

package rmths_pkg;

  localparam int unsigned InValW = 32;
  localparam int unsigned SumW   = 42;
  localparam int unsigned TotW   = 52;
  localparam int unsigned BestW  = 53;

  typedef struct packed {
    logic                     first;
    logic signed [InValW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [BestW-1:0] best_sum;
    logic                    rejected;
  } out_word_t;

endpackage

`default_nettype wire

// ===== sv/running_median_two_heap_signed_sum.sv =====
// running_median_two_heap_signed_sum: two-heap running median over prefix sums
// depends on rmths_pkg (word types, widths); holds both heap memories inline
//
// Use: input words arrive on in_valid_i / in_stall_o, one result word per input
// word leaves on out_valid_o / out_stall_i. A word is taken at a clock edge with
// valid high and stall low. in_word_i.first restarts the sequence.
// Each word runs through a small sequencer around one shared compare/move path
// and one read plus one write port per heap memory. Decode leads to a push whose
// hole walks up, to a sift-down over both children per level and a push of the
// old top, or, for a rejected word, straight to the final output step.
// in_stall_o stays high until the word is finished.
// The result sits in an output register; when the receiver stalls, the
// sequencer holds in its final state until the register is free.
// Reset clears counts, totals, prefix sum and last result; heap memory
// contents are left undefined, as only entries below a heap's count are read.
// A non-first word with MAX_ITEMS items held or its destination heap full gives
// the previous result with the rejected flag set and leaves all state unchanged.
`default_nettype none

module running_median_two_heap_signed_sum #(
  parameter int unsigned MAX_ITEMS   = 1024,
  parameter int unsigned HEAP_DEPTH  = 512,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rmths_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rmths_pkg::out_word_t out_word_o
);
  import rmths_pkg::*;

  localparam int unsigned AW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW    = AW + 2;
  localparam int unsigned WideW = 56;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_PUS  = 4'd2;
  localparam logic [3:0] S_PUC  = 4'd3;
  localparam logic [3:0] S_PUW  = 4'd4;
  localparam logic [3:0] S_SDL  = 4'd5;
  localparam logic [3:0] S_SDR  = 4'd6;
  localparam logic [3:0] S_SDC  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  // heap select: lower is a max-heap, upper a min-heap
  localparam logic H_LO = 1'b0;
  localparam logic H_UP = 1'b1;

  // true when a must sit above b in heap h
  function automatic logic above(logic h, logic signed [SumW-1:0] a,
                                 logic signed [SumW-1:0] b);
    return (h == H_LO) ? (a > b) : (a < b);
  endfunction

  logic [3:0]               state_q, state_d;
  in_word_t                 in_q;
  logic                     h_q, h_d;
  logic signed [SumW-1:0]   v_q, v_d;
  logic [AW-1:0]            i_q, i_d;
  logic [CW-1:0]            n_q, n_d;
  logic                     pend_q, pend_d;
  logic                     pend_h_q, pend_h_d;
  logic signed [SumW-1:0]   pend_v_q, pend_v_d;
  logic                     rej_q, rej_d;
  logic signed [SumW-1:0]   bv_q, bv_d;
  logic [AW-1:0]            bi_q, bi_d;
  logic                     has_r_q, has_r_d;
  logic [CW-1:0]            lo_cnt_q, lo_cnt_d, up_cnt_q, up_cnt_d;
  logic signed [TotW-1:0]   lo_tot_q, lo_tot_d, up_tot_q, up_tot_d;
  logic signed [SumW-1:0]   lo_top_q, lo_top_d, up_top_q, up_top_d;
  logic signed [SumW-1:0]   rsum_q, rsum_d;
  logic signed [BestW-1:0]  last_q, last_d;
  logic                     out_valid_q, out_valid_d;
  out_word_t                out_q, out_d;

  // heap memories
  logic signed [SumW-1:0]   lo_mem [HEAP_DEPTH];
  logic signed [SumW-1:0]   up_mem [HEAP_DEPTH];
  logic signed [SumW-1:0]   rd_lo_q, rd_up_q, rdata;
  logic                     re, we;
  logic [AW-1:0]            raddr, waddr;
  logic signed [SumW-1:0]   wdata;

  always_ff @(posedge clk_i) begin
    if (we && h_q == H_LO) lo_mem[waddr] <= wdata;
    if (we && h_q == H_UP) up_mem[waddr] <= wdata;
    if (re) begin
      rd_lo_q <= lo_mem[raddr];
      rd_up_q <= up_mem[raddr];
    end
  end

  assign rdata = (h_q == H_UP) ? rd_up_q : rd_lo_q;

  // decision path on the accepted word
  logic signed [SumW-1:0]   v_ext, s_new;
  logic signed [SumW:0]     med_sum;
  logic signed [SumW:0]     med;
  logic                     to_lo, rebal, replace, reject, empty;
  logic [CW-1:0]            tc, oc;
  logic signed [SumW-1:0]   top_t;
  logic [CW:0]              cnt_sum;

  assign v_ext   = SumW'(signed'(in_q.value[VALUE_WIDTH-1:0]));
  assign s_new   = rsum_q + v_ext;
  assign med_sum = {lo_top_q[SumW-1], lo_top_q} + {up_top_q[SumW-1], up_top_q};
  assign cnt_sum = {1'b0, lo_cnt_q} + {1'b0, up_cnt_q};
  assign empty   = (lo_cnt_q == '0) && (up_cnt_q == '0);

  always_comb begin
    if (lo_cnt_q == up_cnt_q) begin
      med = (med_sum + $signed({{SumW{1'b0}}, med_sum[SumW]})) >>> 1;
    end else if (lo_cnt_q > up_cnt_q) begin
      med = {lo_top_q[SumW-1], lo_top_q};
    end else begin
      med = {up_top_q[SumW-1], up_top_q};
    end
  end

  assign to_lo   = $signed({s_new[SumW-1], s_new}) <= med;
  assign tc      = to_lo ? lo_cnt_q : up_cnt_q;
  assign oc      = to_lo ? up_cnt_q : lo_cnt_q;
  assign top_t   = to_lo ? lo_top_q : up_top_q;
  assign rebal   = ({1'b0, tc} == {1'b0, oc} + 1'b1);
  assign replace = rebal && above(to_lo ? H_LO : H_UP, top_t, s_new);
  assign reject  = (32'(cnt_sum) >= MAX_ITEMS) ||
                   (rebal && 32'(oc) >= HEAP_DEPTH) ||
                   (!rebal && 32'(tc) >= HEAP_DEPTH);

  // result from totals and tops
  logic signed [WideW-1:0]  diff, adj, lt_w, ut_w, best_w;
  always_comb begin
    diff = WideW'(up_tot_q) - WideW'(lo_tot_q);
    lt_w = (lo_cnt_q != '0) ? WideW'(lo_top_q) : '0;
    ut_w = (up_cnt_q != '0) ? WideW'(up_top_q) : '0;
    adj  = '0;
    if (lo_cnt_q == up_cnt_q) begin
      if (lt_w > 0) adj = lt_w;
      else if (ut_w < 0) adj = -ut_w;
    end else if (lo_cnt_q > up_cnt_q) begin
      if (lt_w > 0) adj = lt_w <<< 1;
    end else begin
      if (ut_w < 0) adj = -(ut_w <<< 1);
    end
    best_w = diff + adj;
  end

  // child indices for sift-down
  logic [XW-1:0] l_idx, r_idx, n_x;
  assign l_idx = {1'b0, i_q, 1'b1};
  assign r_idx = l_idx + 1'b1;
  assign n_x   = XW'(n_q);

  logic                   op_done;
  logic signed [TotW-1:0] lo_base, up_base;

  // sequencer
  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    v_d         = v_q;
    i_d         = i_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_h_d    = pend_h_q;
    pend_v_d    = pend_v_q;
    rej_d       = rej_q;
    bv_d        = bv_q;
    bi_d        = bi_q;
    has_r_d     = has_r_q;
    lo_cnt_d    = lo_cnt_q;
    up_cnt_d    = up_cnt_q;
    lo_tot_d    = lo_tot_q;
    up_tot_d    = up_tot_q;
    lo_top_d    = lo_top_q;
    up_top_d    = up_top_q;
    rsum_d      = rsum_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    re          = 1'b0;
    we          = 1'b0;
    raddr       = '0;
    waddr       = '0;
    wdata       = v_q;
    op_done     = 1'b0;
    lo_base     = lo_tot_q;
    up_base     = up_tot_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DEC;
      end
      S_DEC: begin
        rej_d  = 1'b0;
        pend_d = 1'b0;
        if (in_q.first || (!reject && empty)) begin
          // lone item into an empty pair of heaps
          if (in_q.first) begin
            lo_cnt_d = '0;
            up_cnt_d = '0;
            lo_base  = '0;
            up_base  = '0;
            rsum_d   = v_ext;
            v_d      = v_ext;
          end else begin
            rsum_d = s_new;
            v_d    = s_new;
          end
          lo_tot_d = lo_base;
          up_tot_d = up_base;
          if (v_d >= 0) begin
            h_d      = H_UP;
            up_tot_d = up_base + TotW'(v_d);
          end else begin
            h_d      = H_LO;
            lo_tot_d = lo_base + TotW'(v_d);
          end
          state_d = S_PUS;
        end else if (reject) begin
          rej_d   = 1'b1;
          state_d = S_FIN;
        end else begin
          rsum_d = s_new;
          if (!rebal) begin
            h_d = to_lo ? H_LO : H_UP;
            v_d = s_new;
            if (to_lo) lo_tot_d = lo_tot_q + TotW'(s_new);
            else       up_tot_d = up_tot_q + TotW'(s_new);
            state_d = S_PUS;
          end else if (!replace) begin
            h_d = to_lo ? H_UP : H_LO;
            v_d = s_new;
            if (to_lo) up_tot_d = up_tot_q + TotW'(s_new);
            else       lo_tot_d = lo_tot_q + TotW'(s_new);
            state_d = S_PUS;
          end else begin
            // new sum replaces the top, old top moves across
            h_d      = to_lo ? H_LO : H_UP;
            v_d      = s_new;
            i_d      = '0;
            n_d      = tc;
            pend_d   = 1'b1;
            pend_h_d = to_lo ? H_UP : H_LO;
            pend_v_d = top_t;
            if (to_lo) begin
              lo_tot_d = lo_tot_q + TotW'(s_new) - TotW'(top_t);
              up_tot_d = up_tot_q + TotW'(top_t);
            end else begin
              up_tot_d = up_tot_q + TotW'(s_new) - TotW'(top_t);
              lo_tot_d = lo_tot_q + TotW'(top_t);
            end
            state_d = S_SDL;
          end
        end
      end
      // push: hole walks up from the end
      S_PUS: begin
        if (h_q == H_LO) begin
          i_d      = AW'(lo_cnt_q);
          lo_cnt_d = lo_cnt_q + 1'b1;
        end else begin
          i_d      = AW'(up_cnt_q);
          up_cnt_d = up_cnt_q + 1'b1;
        end
        if (i_d == '0) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = v_q;
          op_done = 1'b1;
        end else begin
          re      = 1'b1;
          raddr   = AW'((i_d - 1'b1) >> 1);
          state_d = S_PUC;
        end
      end
      S_PUC: begin
        if (above(h_q, v_q, rdata)) begin
          we    = 1'b1;
          waddr = i_q;
          wdata = rdata;
          i_d   = AW'((i_q - 1'b1) >> 1);
          if (i_d == '0) begin
            state_d = S_PUW;
          end else begin
            re    = 1'b1;
            raddr = AW'((i_d - 1'b1) >> 1);
          end
        end else begin
          we      = 1'b1;
          waddr   = i_q;
          wdata   = v_q;
          op_done = 1'b1;
        end
      end
      S_PUW: begin
        we      = 1'b1;
        waddr   = i_q;
        wdata   = v_q;
        op_done = 1'b1;
      end
      // sift-down: hole walks down from the top
      S_SDL: begin
        if (l_idx >= n_x) begin
          we      = 1'b1;
          waddr   = i_q;
          wdata   = v_q;
          op_done = 1'b1;
        end else begin
          re      = 1'b1;
          raddr   = l_idx[AW-1:0];
          state_d = S_SDR;
        end
      end
      S_SDR: begin
        if (above(h_q, rdata, v_q)) begin
          bv_d = rdata;
          bi_d = l_idx[AW-1:0];
        end else begin
          bv_d = v_q;
          bi_d = i_q;
        end
        has_r_d = r_idx < n_x;
        if (r_idx < n_x) begin
          re    = 1'b1;
          raddr = r_idx[AW-1:0];
        end
        state_d = S_SDC;
      end
      S_SDC: begin
        if (has_r_q && above(h_q, rdata, bv_q)) begin
          bv_d = rdata;
          bi_d = r_idx[AW-1:0];
        end else begin
          bv_d = bv_q;
          bi_d = bi_q;
        end
        we    = 1'b1;
        waddr = i_q;
        if (bi_d == i_q) begin
          wdata   = v_q;
          op_done = 1'b1;
        end else begin
          wdata   = bv_d;
          i_d     = bi_d;
          state_d = S_SDL;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          if (!rej_q) last_d = best_w[BestW-1:0];
          out_d.best_sum = last_d;
          out_d.rejected = rej_q;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // chain the pending push after the first walk
    if (op_done) begin
      if (pend_q) begin
        pend_d  = 1'b0;
        h_d     = pend_h_q;
        v_d     = pend_v_q;
        state_d = S_PUS;
      end else begin
        state_d = S_FIN;
      end
    end

    // keep the tops in step with entry zero
    if (we && waddr == '0) begin
      if (h_q == H_LO) lo_top_d = wdata;
      else             up_top_d = wdata;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      lo_cnt_q    <= '0;
      up_cnt_q    <= '0;
      lo_tot_q    <= '0;
      up_tot_q    <= '0;
      rsum_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      lo_cnt_q    <= lo_cnt_d;
      up_cnt_q    <= up_cnt_d;
      lo_tot_q    <= lo_tot_d;
      up_tot_q    <= up_tot_d;
      rsum_q      <= rsum_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) in_q <= in_word_i;
    h_q      <= h_d;
    v_q      <= v_d;
    i_q      <= i_d;
    n_q      <= n_d;
    pend_h_q <= pend_h_d;
    pend_v_q <= pend_v_d;
    rej_q    <= rej_d;
    bv_q     <= bv_d;
    bi_q     <= bi_d;
    has_r_q  <= has_r_d;
    lo_top_q <= lo_top_d;
    up_top_q <= up_top_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// tb_top: self-checking bench for running_median_two_heap_signed_sum
// depends on rmths_pkg and the block; predicts each result word in a scoreboard class
`timescale 1ns / 1ps

module tb_top;
  import rmths_pkg::*;

  localparam int unsigned MaxItems  = 1024;
  localparam int unsigned HeapDepth = 512;
  localparam int unsigned NumRandom = 450;

  // running median predictor with its own heaps and totals
  class median_scoreboard;
    longint lo_heap[HeapDepth];
    longint hi_heap[HeapDepth];
    int unsigned lo_cnt, hi_cnt;
    logic signed [TotW-1:0]  lo_tot, hi_tot;
    logic signed [SumW-1:0]  prefix;
    logic signed [BestW-1:0] best;
    out_word_t pending[$];
    int errors;

    function void clear();
      lo_cnt = 0; hi_cnt = 0; lo_tot = '0; hi_tot = '0; prefix = '0; best = '0;
    endfunction

    function bit higher(bit is_max, longint a, longint b);
      return is_max ? (a > b) : (a < b);
    endfunction

    function void push(bit is_max, longint v);
      int unsigned i, p;
      longint t;
      if (is_max) begin
        i = lo_cnt; if (i >= HeapDepth) return;
        lo_heap[i] = v; lo_cnt++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!(lo_heap[i] > lo_heap[p])) break;
          t = lo_heap[i]; lo_heap[i] = lo_heap[p]; lo_heap[p] = t; i = p;
        end
        lo_tot = lo_tot + TotW'(v);
      end else begin
        i = hi_cnt; if (i >= HeapDepth) return;
        hi_heap[i] = v; hi_cnt++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!(hi_heap[i] < hi_heap[p])) break;
          t = hi_heap[i]; hi_heap[i] = hi_heap[p]; hi_heap[p] = t; i = p;
        end
        hi_tot = hi_tot + TotW'(v);
      end
    endfunction

    function void sift(bit is_max, int unsigned n);
      int unsigned i, l, r, m;
      longint t;
      i = 0;
      forever begin
        l = 2 * i + 1; r = l + 1; m = i;
        if (is_max) begin
          if (l < n && lo_heap[l] > lo_heap[m]) m = l;
          if (r < n && lo_heap[r] > lo_heap[m]) m = r;
          if (m == i) return;
          t = lo_heap[i]; lo_heap[i] = lo_heap[m]; lo_heap[m] = t;
        end else begin
          if (l < n && hi_heap[l] < hi_heap[m]) m = l;
          if (r < n && hi_heap[r] < hi_heap[m]) m = r;
          if (m == i) return;
          t = hi_heap[i]; hi_heap[i] = hi_heap[m]; hi_heap[m] = t;
        end
        i = m;
      end
    endfunction

    function void place_alone(longint s);
      push(s < 0, s);
      best = BestW'(s >= 0 ? s : -s);
    endfunction

    // note an accepted input word and queue the result it causes
    function void note_input(in_word_t w);
      longint v, s, med, top, r, lt, ut;
      bit to_lo, rej;
      int unsigned tc, oc;
      out_word_t o;
      v = longint'(w.value);
      rej = 0;
      if (w.first) begin
        clear(); prefix = SumW'(v); place_alone(v);
      end else if (lo_cnt + hi_cnt >= MaxItems) begin
        rej = 1;
      end else begin
        s = longint'($signed(SumW'(prefix + SumW'(v))));
        if (lo_cnt == 0 && hi_cnt == 0) begin
          prefix = SumW'(s); place_alone(s);
        end else begin
          if (lo_cnt == hi_cnt) med = (lo_heap[0] + hi_heap[0]) / 2;
          else if (lo_cnt > hi_cnt) med = lo_heap[0];
          else med = hi_heap[0];
          to_lo = (s <= med);
          tc = to_lo ? lo_cnt : hi_cnt;
          oc = to_lo ? hi_cnt : lo_cnt;
          if (tc == oc + 1) begin
            if (oc >= HeapDepth) rej = 1;
            else begin
              top = to_lo ? lo_heap[0] : hi_heap[0];
              if (!higher(to_lo, top, s)) push(!to_lo, s);
              else if (to_lo) begin
                lo_heap[0] = s; sift(1, tc);
                lo_tot = lo_tot + TotW'(s) - TotW'(top); push(0, top);
              end else begin
                hi_heap[0] = s; sift(0, tc);
                hi_tot = hi_tot + TotW'(s) - TotW'(top); push(1, top);
              end
            end
          end else if (tc >= HeapDepth) rej = 1;
          else push(to_lo, s);
          if (!rej) begin
            r = longint'(hi_tot) - longint'(lo_tot);
            lt = lo_cnt ? lo_heap[0] : 0;
            ut = hi_cnt ? hi_heap[0] : 0;
            prefix = SumW'(s);
            if (lo_cnt == hi_cnt) begin
              if (lt > 0) r += lt; else if (ut < 0) r -= ut;
            end else if (lo_cnt > hi_cnt) begin
              if (lt > 0) r += 2 * lt;
            end else if (ut < 0) r -= 2 * ut;
            best = BestW'(r);
          end
        end
      end
      o.best_sum = best;
      o.rejected = rej;
      pending.push_back(o);
    endfunction

    function void check_result(out_word_t got);
      out_word_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %0d", got.best_sum);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.best_sum !== e.best_sum) begin
        $error("best_sum expected %0d actual %0d", e.best_sum, got.best_sum);
        errors++;
      end
      if (got.rejected !== e.rejected) begin
        $error("rejected expected %0d actual %0d", e.rejected, got.rejected);
        errors++;
      end
    endfunction
  endclass

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_word_t  in_word;
  out_word_t out_word;
  median_scoreboard sb;
  bit        stim_done;

  running_median_two_heap_signed_sum i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // send one word after a random gap and wait until it is taken
  task automatic send_word(bit first, logic signed [InValW-1:0] value);
    int gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{first: first, value: value};
    do @(posedge clk); while (in_stall);
    sb.note_input('{first: first, value: value});
  endtask

  function automatic logic [InValW-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return {$urandom_range(0, 1) ? 24'hffffff : 24'h0, 8'($urandom())};
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // result side: random stalls and a check on every taken word
  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_word);
    end
  end

  initial begin
    int n;
    sb = new();
    sb.clear();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_word  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, empty-heap continuation, sign cases
    send_word(0, 32'sd5);
    send_word(0, -32'sd9);
    send_word(0, 32'sh7fffffff);
    send_word(0, 32'sh7fffffff);
    send_word(0, 32'sh80000000);
    send_word(1, -32'sd3);
    send_word(0, -32'sd4);
    send_word(0, -32'sd2);
    send_word(0, 32'sd0);
    send_word(1, 32'sh80000000);
    send_word(0, 32'sh80000000);
    send_word(0, 32'sh80000000);
    send_word(1, 32'sd0);
    send_word(0, 32'sd1);
    send_word(0, -32'sd1);
    send_word(0, 32'sd7);
    send_word(0, -32'sd20);
    send_word(1, 32'sh7fffffff);
    send_word(0, 32'shffffffff);
    // fill to capacity then push rejected words
    send_word(1, 32'sd1);
    for (int i = 0; i < MaxItems + 4; i++) send_word(0, rand_value());
    // random sequences of varied length
    n = 0;
    while (n < NumRandom) begin
      send_word(1, rand_value()); n++;
      repeat ($urandom_range(0, 60)) begin
        send_word(0, rand_value()); n++;
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
